### rtl/montgomery_modular_alu_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Montgomery modular ALU checker
// Same-cycle and next-cycle implications with a clock and a disable term.
// ---------------------------------------------------------------------------
`ifndef MONTGOMERY_MODULAR_ALU_UNIT_ASSERT_SVH
`define MONTGOMERY_MODULAR_ALU_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MMAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mmau_pkg.sv
// ---------------------------------------------------------------------------
// mmau_pkg
// Codes, control word layout and microcode ROM of the Montgomery modular ALU.
// ---------------------------------------------------------------------------
package mmau_pkg;

   localparam int unsigned PC_W = 5;

   // operation codes on req_func
   localparam logic [2:0] FUNC_MUL       = 3'd0;
   localparam logic [2:0] FUNC_ADD       = 3'd1;
   localparam logic [2:0] FUNC_SUB       = 3'd2;
   localparam logic [2:0] FUNC_POW       = 3'd3;
   localparam logic [2:0] FUNC_TO_MONT   = 3'd4;
   localparam logic [2:0] FUNC_FROM_MONT = 3'd5;
   localparam logic [2:0] FUNC_DIV       = 3'd6;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_R2      = 2'd1;
   localparam logic [1:0] CSR_NINV    = 2'd2;

   // micro-operations
   localparam logic [3:0] OP_NOP  = 4'd0;  // only a jump test
   localparam logic [3:0] OP_MXY  = 4'd1;  // t = x * y
   localparam logic [3:0] OP_MK   = 4'd2;  // k = t * ninv mod 2^32
   localparam logic [3:0] OP_MM   = 4'd3;  // m = k * P
   localparam logic [3:0] OP_RED  = 4'd4;  // (t + m) >> 32 to dst
   localparam logic [3:0] OP_ADD  = 4'd5;
   localparam logic [3:0] OP_SUB  = 4'd6;
   localparam logic [3:0] OP_FIN  = 4'd7;  // r mod P, one subtract
   localparam logic [3:0] OP_MOV  = 4'd8;  // result = r
   localparam logic [3:0] OP_ZERO = 4'd9;  // result = 0

   // multiplier x operand
   localparam logic [1:0] X_A   = 2'd0;
   localparam logic [1:0] X_V   = 2'd1;
   localparam logic [1:0] X_R   = 2'd2;
   localparam logic [1:0] X_ONE = 2'd3;

   // multiplier y operand
   localparam logic [2:0] Y_B   = 3'd0;
   localparam logic [2:0] Y_V   = 3'd1;
   localparam logic [2:0] Y_R   = 3'd2;
   localparam logic [2:0] Y_R2  = 3'd3;
   localparam logic [2:0] Y_ONE = 3'd4;

   // reduction destination
   localparam logic [1:0] D_R   = 2'd0;
   localparam logic [1:0] D_V   = 2'd1;
   localparam logic [1:0] D_RES = 2'd2;

   // jump conditions
   localparam logic [2:0] J_NONE = 3'd0;
   localparam logic [2:0] J_ALW  = 3'd1;
   localparam logic [2:0] J_XZ   = 3'd2;  // exponent exhausted
   localparam logic [2:0] J_X0   = 3'd3;  // exponent bit clear
   localparam logic [2:0] J_DIV  = 3'd4;  // item is a divide

   // program addresses
   localparam logic [PC_W-1:0] ENT_MUL     = 5'd0;
   localparam logic [PC_W-1:0] ADR_MK      = 5'd1;
   localparam logic [PC_W-1:0] ENT_TO_MONT = 5'd4;
   localparam logic [PC_W-1:0] ENT_ADD     = 5'd5;
   localparam logic [PC_W-1:0] ENT_SUB     = 5'd6;
   localparam logic [PC_W-1:0] ENT_FROM    = 5'd7;
   localparam logic [PC_W-1:0] ENT_ZERO    = 5'd12;
   localparam logic [PC_W-1:0] ENT_POW     = 5'd13;
   localparam logic [PC_W-1:0] ADR_LOOP    = 5'd17;
   localparam logic [PC_W-1:0] ADR_SQ      = 5'd23;
   localparam logic [PC_W-1:0] ADR_PDONE   = 5'd27;
   localparam logic [PC_W-1:0] ADR_DTAIL   = 5'd29;

   typedef struct packed {
      logic [3:0]      op;
      logic [1:0]      xsel;
      logic [2:0]      ysel;
      logic [1:0]      dst;
      logic            shx;   // shift exponent right
      logic [2:0]      jc;
      logic [PC_W-1:0] jt;
      logic            last;  // writes the result register, item done
   } ucode_type;

   typedef struct packed {
      logic x_zero;
      logic x_even;
      logic is_div;
   } cond_type;

   function automatic ucode_type uc(input logic [3:0] op, input logic [1:0] xsel,
                                    input logic [2:0] ysel, input logic [1:0] dst,
                                    input logic shx, input logic [2:0] jc,
                                    input logic [PC_W-1:0] jt, input logic last);
      ucode_type w;
      w.op   = op;
      w.xsel = xsel;
      w.ysel = ysel;
      w.dst  = dst;
      w.shx  = shx;
      w.jc   = jc;
      w.jt   = jt;
      w.last = last;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         // multiply, shared Montgomery tail
         5'd0:  w = uc(OP_MXY,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd1:  w = uc(OP_MK,   X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd2:  w = uc(OP_MM,   X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd3:  w = uc(OP_RED,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         // to_mont
         5'd4:  w = uc(OP_MXY,  X_A,   Y_R2,  D_RES, 1'b0, J_ALW,  ADR_MK,    1'b0);
         // add, sub
         5'd5:  w = uc(OP_ADD,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         5'd6:  w = uc(OP_SUB,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         // from_mont
         5'd7:  w = uc(OP_MXY,  X_A,   Y_ONE, D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd8:  w = uc(OP_MK,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd9:  w = uc(OP_MM,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd10: w = uc(OP_RED,  X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd11: w = uc(OP_FIN,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         // zero result: unused code or bad exponent
         5'd12: w = uc(OP_ZERO, X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         // power: r = mont(1, R^2)
         5'd13: w = uc(OP_MXY,  X_ONE, Y_R2,  D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd14: w = uc(OP_MK,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd15: w = uc(OP_MM,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd16: w = uc(OP_RED,  X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         // bit loop
         5'd17: w = uc(OP_NOP,  X_A,   Y_B,   D_R,   1'b0, J_XZ,   ADR_PDONE, 1'b0);
         5'd18: w = uc(OP_NOP,  X_A,   Y_B,   D_R,   1'b0, J_X0,   ADR_SQ,    1'b0);
         5'd19: w = uc(OP_MXY,  X_R,   Y_V,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd20: w = uc(OP_MK,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd21: w = uc(OP_MM,   X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd22: w = uc(OP_RED,  X_A,   Y_B,   D_R,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd23: w = uc(OP_MXY,  X_V,   Y_V,   D_V,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd24: w = uc(OP_MK,   X_A,   Y_B,   D_V,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd25: w = uc(OP_MM,   X_A,   Y_B,   D_V,   1'b0, J_NONE, ENT_MUL,   1'b0);
         5'd26: w = uc(OP_RED,  X_A,   Y_B,   D_V,   1'b1, J_ALW,  ADR_LOOP,  1'b0);
         // loop exit
         5'd27: w = uc(OP_NOP,  X_A,   Y_B,   D_R,   1'b0, J_DIV,  ADR_DTAIL, 1'b0);
         5'd28: w = uc(OP_MOV,  X_A,   Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
         // divide tail: a * b^-1
         5'd29: w = uc(OP_MXY,  X_A,   Y_R,   D_RES, 1'b0, J_ALW,  ADR_MK,    1'b0);
         default: w = uc(OP_ZERO, X_A, Y_B,   D_RES, 1'b0, J_NONE, ENT_MUL,   1'b1);
      endcase
      return w;
   endfunction

endpackage

### rtl/mmau_seq.sv
// ---------------------------------------------------------------------------
// mmau_seq
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// ---------------------------------------------------------------------------
module mmau_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mmau_pkg::PC_W-1:0] entry,
   input  logic                      hold,
   input  mmau_pkg::cond_type        cond,
   output mmau_pkg::ucode_type       cw,
   output logic                      busy
);

   logic [mmau_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      busy_ff, busy_in;
   logic                      taken;

   assign cw   = mmau_pkg::ucode_rom(pc_ff);
   assign busy = busy_ff;

   always_comb begin
      case (cw.jc)
         mmau_pkg::J_ALW: taken = 1'b1;
         mmau_pkg::J_XZ:  taken = cond.x_zero;
         mmau_pkg::J_X0:  taken = cond.x_even;
         mmau_pkg::J_DIV: taken = cond.is_div;
         default:         taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = entry;
         busy_in = 1'b1;
      end else if (busy_ff && !hold) begin
         if (cw.last) begin
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = cw.jt;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

### rtl/montgomery_modular_alu_unit.sv
// ---------------------------------------------------------------------------
// montgomery_modular_alu_unit
// Montgomery modular ALU, prime modulus below 2^30, R = 2^32, run by microcode.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Ports                                         Beat
//  req      in         req_func, req_first_value, req_second_value   valid & ready
//  rsp      out        rsp_result, rsp_exponent_error                valid & ready
//  csr      in         csr_index, csr_write_data                     csr_write_enable
//
//  One beat in gives one beat out. Each Montgomery product takes four
//  steps: a*b, t*ninv and k*P on the one 32x32 multiplier, then the add
//  and shift. Power first forms r = mont(1, R^2), then for each exponent
//  bit multiplies r by v if the bit is set and squares v, until the
//  exponent is used up; power then moves r to the result, while divide
//  ends with a Montgomery product of a and r.
//  Reset clears the sequencer and the output valid and loads defaults into the csr registers.
//  A finished result waits in the output register; a new beat is taken as
//  soon as the sequencer is free, and the sequencer holds on its final step
//  while the output register is still full.
//
module montgomery_modular_alu_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [30:0]        req_first_value,
   input  logic signed [62:0] req_second_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_result,
   output logic               rsp_exponent_error,
   // configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   // configuration registers
   logic [29:0] modulus_ff;
   logic [29:0] r2_ff;
   logic [31:0] ninv_ff;

   // operand and working registers
   logic [30:0] a_ff;
   logic [30:0] b_ff;
   logic [31:0] v_ff;     // base of the power loop
   logic [31:0] r_ff;     // running product
   logic [62:0] x_ff;     // offset exponent, shifted as bits are used
   logic [63:0] t_ff;
   logic [31:0] k_ff;
   logic [61:0] m_ff;
   logic        div_ff;
   logic        err_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_result_ff;
   logic        rsp_error_ff;

   // sequencer link
   mmau_pkg::ucode_type          cw;
   mmau_pkg::cond_type           cond;
   logic [mmau_pkg::PC_W-1:0]    entry;
   logic                         busy;
   logic                         hold;
   logic                         exec;
   logic                         accept;

   // accept-time exponent handling
   logic [63:0] e_ext;
   logic [63:0] p_ext;
   logic [63:0] off_pow;
   logic [63:0] off_div;
   logic [63:0] off_sel;
   logic        is_div;
   logic        is_pow;
   logic        neg;

   // datapath
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] prod;
   logic [63:0] red_sum;
   logic [31:0] a32;
   logic [31:0] b32;
   logic [31:0] p2;
   logic [31:0] p32;
   logic [31:0] add_sum;
   logic [31:0] add_res;
   logic [31:0] sub_res;
   logic [31:0] fin_res;
   logic [31:0] res_val;

   assign req_ready          = !busy;
   assign accept             = req_valid && req_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_exponent_error = rsp_error_ff;

   // final step may not overwrite a result nobody has taken yet
   assign hold = cw.last && rsp_valid_ff && !rsp_ready;
   assign exec = busy && !hold;

   // --- exponent offset: e + P - 1 for power, P - 2 for divide ---
   assign e_ext   = {req_second_value[62], req_second_value};
   assign p_ext   = {34'd0, modulus_ff};
   assign off_pow = e_ext + p_ext - 64'd1;
   assign off_div = p_ext - 64'd2;
   assign is_div  = (req_func == mmau_pkg::FUNC_DIV);
   assign is_pow  = (req_func == mmau_pkg::FUNC_POW);
   assign off_sel = is_div ? off_div : off_pow;
   assign neg     = off_sel[63] && (is_div || is_pow);

   always_comb begin
      case (req_func)
         mmau_pkg::FUNC_MUL:       entry = mmau_pkg::ENT_MUL;
         mmau_pkg::FUNC_ADD:       entry = mmau_pkg::ENT_ADD;
         mmau_pkg::FUNC_SUB:       entry = mmau_pkg::ENT_SUB;
         mmau_pkg::FUNC_POW:       entry = neg ? mmau_pkg::ENT_ZERO : mmau_pkg::ENT_POW;
         mmau_pkg::FUNC_TO_MONT:   entry = mmau_pkg::ENT_TO_MONT;
         mmau_pkg::FUNC_FROM_MONT: entry = mmau_pkg::ENT_FROM;
         mmau_pkg::FUNC_DIV:       entry = neg ? mmau_pkg::ENT_ZERO : mmau_pkg::ENT_POW;
         default:                  entry = mmau_pkg::ENT_ZERO;
      endcase
   end

   assign cond.x_zero = (x_ff == '0);
   assign cond.x_even = !x_ff[0];
   assign cond.is_div = div_ff;

   mmau_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .entry (entry),
      .hold  (hold),
      .cond  (cond),
      .cw    (cw),
      .busy  (busy)
   );

   // --- shared multiplier, operands chosen by the control word ---
   always_comb begin
      case (cw.xsel)
         mmau_pkg::X_A:   mul_x = {1'b0, a_ff};
         mmau_pkg::X_V:   mul_x = v_ff;
         mmau_pkg::X_R:   mul_x = r_ff;
         default:         mul_x = 32'd1;
      endcase
      case (cw.ysel)
         mmau_pkg::Y_B:   mul_y = {1'b0, b_ff};
         mmau_pkg::Y_V:   mul_y = v_ff;
         mmau_pkg::Y_R:   mul_y = r_ff;
         mmau_pkg::Y_R2:  mul_y = {2'b00, r2_ff};
         default:         mul_y = 32'd1;
      endcase
      // reduction phases use fixed operands
      case (cw.op)
         mmau_pkg::OP_MK: begin
            mul_x = t_ff[31:0];
            mul_y = ninv_ff;
         end
         mmau_pkg::OP_MM: begin
            mul_x = k_ff;
            mul_y = {2'b00, modulus_ff};
         end
         default: begin
         end
      endcase
   end

   assign prod    = {32'd0, mul_x} * {32'd0, mul_y};
   assign red_sum = t_ff + {2'b00, m_ff};   // wraps at 2^64

   // --- lazy add / sub, final subtract ---
   assign a32     = {1'b0, a_ff};
   assign b32     = {1'b0, b_ff};
   assign p2      = {1'b0, modulus_ff, 1'b0};
   assign p32     = {2'b00, modulus_ff};
   assign add_sum = a32 + b32;
   assign add_res = (add_sum < p2) ? add_sum : add_sum - p2;
   assign sub_res = (a32 < b32) ? p2 - b32 + a32 : a32 - b32;
   assign fin_res = (r_ff < p32) ? r_ff : r_ff - p32;

   always_comb begin
      case (cw.op)
         mmau_pkg::OP_RED: res_val = red_sum[63:32];
         mmau_pkg::OP_ADD: res_val = add_res;
         mmau_pkg::OP_SUB: res_val = sub_res;
         mmau_pkg::OP_FIN: res_val = fin_res;
         mmau_pkg::OP_MOV: res_val = r_ff;
         default:          res_val = 32'd0;
      endcase
   end

   // --- configuration registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 30'd3;
         r2_ff      <= 30'd1;
         ninv_ff    <= 32'd1431655765;
      end else if (csr_write_enable) begin
         case (csr_index)
            mmau_pkg::CSR_MODULUS: modulus_ff <= csr_write_data[29:0];
            mmau_pkg::CSR_R2:      r2_ff      <= csr_write_data[29:0];
            mmau_pkg::CSR_NINV:    ninv_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // --- operand load and datapath steps (no reset needed) ---
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff   <= req_first_value;
         b_ff   <= req_second_value[30:0];
         v_ff   <= is_div ? {1'b0, req_second_value[30:0]} : {1'b0, req_first_value};
         x_ff   <= off_sel[62:0];
         div_ff <= is_div;
         err_ff <= neg;
      end else if (exec) begin
         case (cw.op)
            mmau_pkg::OP_MXY: t_ff <= prod;
            mmau_pkg::OP_MK:  k_ff <= prod[31:0];
            mmau_pkg::OP_MM:  m_ff <= prod[61:0];
            mmau_pkg::OP_RED: begin
               if (cw.dst == mmau_pkg::D_R) begin
                  r_ff <= red_sum[63:32];
               end
               if (cw.dst == mmau_pkg::D_V) begin
                  v_ff <= red_sum[63:32];
               end
            end
            default: begin
            end
         endcase
         if (cw.shx) begin
            x_ff <= x_ff >> 1;
         end
      end
   end

   // --- output register ---
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec && cw.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && cw.last) begin
         rsp_result_ff <= res_val[30:0];
         rsp_error_ff  <= err_ff;
      end
   end

endmodule

### rtl/mmau_chk.sv
// ---------------------------------------------------------------------------
// mmau_chk
// Port-level checks of the Montgomery modular ALU, bound to the top level.
// ---------------------------------------------------------------------------
`include "montgomery_modular_alu_unit_assert.svh"

module mmau_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_func,
   input logic [30:0]        req_first_value,
   input logic signed [62:0] req_second_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [30:0]        rsp_result,
   input logic               rsp_exponent_error,
   input logic               csr_write_enable,
   input logic [1:0]         csr_index,
   input logic [31:0]        csr_write_data
);

   // a stalled result beat stays put
   `MMAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result) && $stable(rsp_exponent_error), "rsp beat changed while stalled")

   // one item in work at a time
   `MMAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "second beat taken while busy")

   // a failed power or divide answers zero
   `MMAU_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_exponent_error, rsp_result == 31'd0, "exponent error with nonzero result")

   // reset leaves the block idle and empty
   `MMAU_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind montgomery_modular_alu_unit mmau_chk u_mmau_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_func           (req_func),
   .req_first_value    (req_first_value),
   .req_second_value   (req_second_value),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result         (rsp_result),
   .rsp_exponent_error (rsp_exponent_error),
   .csr_write_enable   (csr_write_enable),
   .csr_index          (csr_index),
   .csr_write_data     (csr_write_data)
);
